[hw/rtl/kmer_presence_hash_table_core_macros.svh]
// Assertion macros for the k-mer table RTL (used by kpht_back).
// No dependencies; include with the bare file name.
`ifndef KMER_PRESENCE_HASH_TABLE_CORE_MACROS_SVH
`define KMER_PRESENCE_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KPHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KPHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/kpht_pkg.sv]
// Package for the k-mer presence table: field widths, codes, state enums, job record.
// No dependencies.
`timescale 1ns / 1ps
package kpht_pkg;

	localparam int KEY_W  = 62;
	localparam int MASK_W = 32;
	localparam int SP_W   = 5;
	localparam int RB_W   = 10;
	localparam int RWY_W  = 2;
	localparam int ST_W   = 3;
	localparam int SLOT_W = KEY_W + MASK_W;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} kpht_cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_FWD  = 3'd0,
		ST_RC   = 3'd1,
		ST_NEW  = 3'd2,
		ST_FULL = 3'd3,
		ST_DONE = 3'd4
	} kpht_status_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} kpht_front_state_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_RA,
		BK_CA,
		BK_RB,
		BK_CB,
		BK_CLR
	} kpht_back_state_t;

	typedef struct packed {
		kpht_cmd_t           cmd;
		logic [KEY_W-1:0]    key;
		logic [KEY_W-1:0]    rc;
		logic [MASK_W-1:0]   bit_mask;
		logic [3:0]          way;
		logic                rd_ok;
	} kpht_job_t;

endpackage

[hw/rtl/kpht_req_if.sv]
// Request channel interface: valid/ready handshake with the command payload.
// Depends on kpht_pkg.
`timescale 1ns / 1ps
interface kpht_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [kpht_pkg::KEY_W-1:0]    kmer_key;
	logic [kpht_pkg::KEY_W-1:0]    rc_key;
	logic [kpht_pkg::SP_W-1:0]     species;
	logic [kpht_pkg::RB_W-1:0]     slot_bucket;
	logic [kpht_pkg::RWY_W-1:0]    slot_way;

	modport source (output valid, command, kmer_key, rc_key, species, slot_bucket,
		slot_way, input ready);
	modport sink (input valid, command, kmer_key, rc_key, species, slot_bucket,
		slot_way, output ready);
endinterface

[hw/rtl/kpht_rsp_if.sv]
// Result channel interface: valid/ready handshake with the result payload.
// Depends on kpht_pkg.
`timescale 1ns / 1ps
interface kpht_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [kpht_pkg::ST_W-1:0]     status;
	logic                          entry_valid;
	logic [kpht_pkg::KEY_W-1:0]    entry_key;
	logic [kpht_pkg::MASK_W-1:0]   species_mask;

	modport source (output valid, status, entry_valid, entry_key, species_mask,
		input ready);
	modport sink (input valid, status, entry_valid, entry_key, species_mask,
		output ready);
endinterface

[hw/rtl/kmer_presence_hash_table_core.sv]
// Insert: the front folds the key bytes and reduces the sums by compare-subtract steps; the back
// then searches the key bucket, and the reverse-complement bucket after a forward miss.
// Read fetches one row; an unused command just returns a result; clear sweeps the fill counts.
// The front takes a new request only once its job is queued; the back runs one job at a time.
// Reset: async, active low; a clearing pass over all buckets then runs and holds req.ready low.
// Depends on kpht_pkg, kpht_req_if, kpht_rsp_if, kpht_front, kpht_queue, kpht_back.
`timescale 1ns / 1ps
module kmer_presence_hash_table_core #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4,
	parameter int SPECIES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	kpht_req_if.sink  req,
	kpht_rsp_if.source rsp
);
	// Bucket index width (front and back) and job record width (front, queue and back).
	localparam int BW = $clog2(BUCKETS);
	localparam int JW = $bits(kpht_pkg::kpht_job_t) + 2 * BW;

	logic          push_valid, push_ready, pop_valid, pop_ready, init_busy;
	logic [JW-1:0] push_data, pop_data;

	// Front: takes each transfer, reduces both keys modulo BUCKETS for inserts,
	// range-checks read addresses, then hands a job to the queue.
	kpht_front #(
		.BUCKETS(BUCKETS), .WAYS(WAYS), .SPECIES(SPECIES), .BW(BW), .JW(JW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .init_busy(init_busy),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	// Queue: decouples the two halves so the front can start the next remainder
	// while the back is still searching or waiting on the result register.
	kpht_queue #(.W(JW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
	);

	// Back: searches the key bucket then the reverse-complement bucket, writes
	// the updated row back, sweeps fill counts on clear, and drives the result.
	kpht_back #(
		.BUCKETS(BUCKETS), .WAYS(WAYS), .BW(BW), .JW(JW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.init_busy(init_busy), .rsp(rsp)
	);
endmodule

[hw/rtl/kpht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module kpht_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/kpht_front.sv]
// Front end: accepts requests, works out home buckets of both keys, queues the job.
// Depends on kpht_pkg and kpht_req_if.
`timescale 1ns / 1ps
module kpht_front #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4,
	parameter int SPECIES = 32,
	parameter int BW      = $clog2(BUCKETS),
	parameter int JW      = $bits(kpht_pkg::kpht_job_t) + 2 * BW
) (
	input  logic         clk,
	input  logic         arst_n,
	kpht_req_if.sink     req,
	input  logic         init_busy,
	output logic         push_valid,
	input  logic         push_ready,
	output logic [JW-1:0] push_data
);
	// Eight byte digits of the key; their weighted sum stays below 2^11 * BUCKETS,
	// so eleven compare-subtract steps bring it below BUCKETS.
	localparam int NDIG = 8;
	localparam int RS   = 11;
	localparam int SWD  = BW + RS;
	localparam logic [SWD-1:0] BX = SWD'(BUCKETS);

	// Weight of byte i: 2^(8*i) mod BUCKETS, worked out at elaboration.
	function automatic logic [NDIG*BW-1:0] fold_weights();
		logic [NDIG*BW-1:0] w;
		longint unsigned    m;
		w = '0;
		m = 64'd1 % 64'(BUCKETS);
		for (int i = 0; i < NDIG; i++) begin
			w[i*BW +: BW] = BW'(m);
			m = (m * 64'd256) % 64'(BUCKETS);
		end
		return w;
	endfunction

	localparam logic [NDIG*BW-1:0] WGT = fold_weights();

	kpht_pkg::kpht_front_state_t state_q, state_d;
	kpht_pkg::kpht_job_t         job_q;
	logic [63:0]                 sk_q, sr_q;
	logic [SWD-1:0]              fk_q, fr_q;
	logic [1:0]                  cnt_q;
	logic                        acc;

	// Sum of byte digits times their weights; congruent to the key mod BUCKETS.
	function automatic logic [SWD-1:0] fold_key(input logic [63:0] k);
		logic [SWD-1:0] s;
		s = '0;
		for (int i = 0; i < NDIG; i++) begin
			s = s + SWD'(k[i*8 +: 8]) * SWD'(WGT[i*BW +: BW]);
		end
		return s;
	endfunction

	// Four compare-subtract steps against BUCKETS shifted by hi down to hi-3.
	function automatic logic [SWD-1:0] reduce4(input logic [SWD-1:0] s, input int hi);
		logic [SWD-1:0] a;
		a = s;
		for (int j = 0; j < 4; j++) begin
			if (hi - j >= 0) begin
				if (a >= (BX << (hi - j))) begin
					a = a - (BX << (hi - j));
				end
			end
		end
		return a;
	endfunction

	assign req.ready  = (state_q == kpht_pkg::FR_IDLE) && !init_busy;
	assign acc        = req.valid && req.ready;
	assign push_valid = (state_q == kpht_pkg::FR_PUSH);
	assign push_data  = {job_q, fk_q[BW-1:0], fr_q[BW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpht_pkg::FR_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				cnt_q <= '0;
			end else if (state_q == kpht_pkg::FR_DIV) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			kpht_pkg::FR_IDLE: begin
				if (acc) begin
					state_d = (kpht_pkg::kpht_cmd_t'(req.command) == kpht_pkg::CMD_INSERT)
						? kpht_pkg::FR_DIV : kpht_pkg::FR_PUSH;
				end
			end
			kpht_pkg::FR_DIV: begin
				if (cnt_q == 2'd3) begin
					state_d = kpht_pkg::FR_PUSH;
				end
			end
			kpht_pkg::FR_PUSH: begin
				if (push_ready) begin
					state_d = kpht_pkg::FR_IDLE;
				end
			end
			default: state_d = kpht_pkg::FR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			job_q.cmd      <= kpht_pkg::kpht_cmd_t'(req.command);
			job_q.key      <= req.kmer_key;
			job_q.rc       <= req.rc_key;
			job_q.bit_mask <= (32'(req.species) < 32'(SPECIES))
				? (32'd1 << req.species) : '0;
			job_q.way      <= {2'b00, req.slot_way};
			job_q.rd_ok    <= (32'(req.slot_bucket) < 32'(BUCKETS))
				&& (32'(req.slot_way) < 32'(WAYS));
			sk_q <= {2'b00, req.kmer_key};
			sr_q <= {2'b00, req.rc_key};
			fk_q <= (kpht_pkg::kpht_cmd_t'(req.command) == kpht_pkg::CMD_READ)
				? SWD'(req.slot_bucket) : '0;
			fr_q <= '0;
		end else if (state_q == kpht_pkg::FR_DIV) begin
			// fold both keys, then reduce the sums by compare-subtract steps
			case (cnt_q)
				2'd0: begin
					fk_q <= fold_key(sk_q);
					fr_q <= fold_key(sr_q);
				end
				2'd1: begin
					fk_q <= reduce4(fk_q, 10);
					fr_q <= reduce4(fr_q, 10);
				end
				2'd2: begin
					fk_q <= reduce4(fk_q, 6);
					fr_q <= reduce4(fr_q, 6);
				end
				default: begin
					fk_q <= reduce4(fk_q, 2);
					fr_q <= reduce4(fr_q, 2);
				end
			endcase
		end
	end
endmodule

[hw/rtl/kpht_queue.sv]
// Two-entry job queue between front and back end.
// No dependencies.
`timescale 1ns / 1ps
module kpht_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_data;
		end
	end
endmodule

[hw/rtl/kpht_back.sv]
// Back end: bucket searches, read-modify-write of table rows, clear sweeps, result register.
// Depends on kpht_pkg, kpht_ram, kpht_rsp_if and the assertion macro header.
`timescale 1ns / 1ps
`include "kmer_presence_hash_table_core_macros.svh"
module kpht_back #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4,
	parameter int BW      = $clog2(BUCKETS),
	parameter int JW      = $bits(kpht_pkg::kpht_job_t) + 2 * BW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  logic [JW-1:0] pop_data,
	output logic          init_busy,
	kpht_rsp_if.source    rsp
);
	localparam int SW = kpht_pkg::SLOT_W;
	localparam int MW = kpht_pkg::MASK_W;
	localparam int KW = kpht_pkg::KEY_W;
	localparam int RW = WAYS * SW;
	localparam int FW = $clog2(WAYS + 1);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	kpht_pkg::kpht_back_state_t state_q, state_d;
	kpht_pkg::kpht_job_t        job_q, pop_job;
	logic [BW-1:0]              bk_q, br_q, pop_bk, pop_br, clr_cnt_q;
	logic [RW-1:0]              row_a_q;
	logic [FW-1:0]              fill_a_q;

	logic                  out_valid_q;
	kpht_pkg::kpht_status_t out_status_q;
	logic                  out_ev_q;
	logic [KW-1:0]         out_key_q;
	logic [MW-1:0]         out_mask_q;

	logic          d_we, f_we, do_pop, clr_last;
	logic [BW-1:0] d_waddr, f_waddr, raddr;
	logic [RW-1:0] d_wdata, d_rdata, merged_row, new_row;
	logic [FW-1:0] f_wdata, f_rdata;

	logic                   hit;
	logic [WW-1:0]          hit_way;
	logic [KW-1:0]          cmp_key, hit_key, rd_key;
	logic [MW-1:0]          hit_mask, rd_mask;
	logic                   rd_valid;
	logic                   res_load, res_ev;
	kpht_pkg::kpht_status_t res_status;
	logic [KW-1:0]          res_key;
	logic [MW-1:0]          res_mask;

	assign {pop_job, pop_bk, pop_br} = pop_data;
	assign do_pop    = pop_valid && pop_ready;
	assign init_busy = (state_q == kpht_pkg::BK_INIT);
	assign clr_last  = (clr_cnt_q == BW'(BUCKETS - 1));
	assign raddr     = (state_q == kpht_pkg::BK_RB) ? br_q : bk_q;

	kpht_ram #(.W(RW), .D(BUCKETS)) u_row_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(raddr), .rdata(d_rdata)
	);

	kpht_ram #(.W(FW), .D(BUCKETS)) u_fill_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(raddr), .rdata(f_rdata)
	);

	// Search the row just read; the bucket's fill count says which ways are live.
	always_comb begin
		cmp_key    = (state_q == kpht_pkg::BK_CB) ? job_q.rc : job_q.key;
		hit        = 1'b0;
		hit_way    = '0;
		hit_key    = '0;
		hit_mask   = '0;
		rd_key     = '0;
		rd_mask    = '0;
		merged_row = d_rdata;
		new_row    = row_a_q;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && (32'(w) < 32'(f_rdata))
				&& (d_rdata[w*SW+MW +: KW] == cmp_key)) begin
				hit     = 1'b1;
				hit_way = WW'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (WW'(w) == hit_way) begin
				hit_key                = d_rdata[w*SW+MW +: KW];
				hit_mask               = d_rdata[w*SW +: MW] | job_q.bit_mask;
				merged_row[w*SW +: MW] = d_rdata[w*SW +: MW] | job_q.bit_mask;
			end
			if (WW'(w) == job_q.way[WW-1:0]) begin
				rd_key  = d_rdata[w*SW+MW +: KW];
				rd_mask = d_rdata[w*SW +: MW];
			end
			if (FW'(w) == fill_a_q) begin
				new_row[w*SW +: SW] = {job_q.key, job_q.bit_mask};
			end
		end
		rd_valid = job_q.rd_ok && (32'(job_q.way) < 32'(f_rdata));
	end

	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		d_we       = 1'b0;
		d_waddr    = bk_q;
		d_wdata    = merged_row;
		f_we       = 1'b0;
		f_waddr    = bk_q;
		f_wdata    = '0;
		res_load   = 1'b0;
		res_status = kpht_pkg::ST_DONE;
		res_ev     = 1'b0;
		res_key    = '0;
		res_mask   = '0;
		case (state_q)
			kpht_pkg::BK_INIT: begin
				f_we    = 1'b1;
				f_waddr = clr_cnt_q;
				if (clr_last) begin
					state_d = kpht_pkg::BK_IDLE;
				end
			end
			kpht_pkg::BK_IDLE: begin
				// take a job only once the previous result has gone
				pop_ready = !out_valid_q;
				if (do_pop) begin
					case (pop_job.cmd)
						kpht_pkg::CMD_INSERT: state_d = kpht_pkg::BK_RA;
						kpht_pkg::CMD_READ:   state_d = kpht_pkg::BK_RA;
						kpht_pkg::CMD_CLEAR:  state_d = kpht_pkg::BK_CLR;
						default:              res_load = 1'b1;
					endcase
				end
			end
			kpht_pkg::BK_RA: begin
				state_d = kpht_pkg::BK_CA;
			end
			kpht_pkg::BK_CA: begin
				if (job_q.cmd == kpht_pkg::CMD_READ) begin
					res_load = 1'b1;
					res_ev   = rd_valid;
					res_key  = rd_valid ? rd_key : '0;
					res_mask = rd_valid ? rd_mask : '0;
					state_d  = kpht_pkg::BK_IDLE;
				end else if (hit) begin
					d_we       = 1'b1;
					res_load   = 1'b1;
					res_status = kpht_pkg::ST_FWD;
					res_ev     = 1'b1;
					res_key    = hit_key;
					res_mask   = hit_mask;
					state_d    = kpht_pkg::BK_IDLE;
				end else begin
					state_d = kpht_pkg::BK_RB;
				end
			end
			kpht_pkg::BK_RB: begin
				state_d = kpht_pkg::BK_CB;
			end
			kpht_pkg::BK_CB: begin
				res_load = 1'b1;
				state_d  = kpht_pkg::BK_IDLE;
				if (hit) begin
					d_we       = 1'b1;
					d_waddr    = br_q;
					res_status = kpht_pkg::ST_RC;
					res_ev     = 1'b1;
					res_key    = hit_key;
					res_mask   = hit_mask;
				end else if (32'(fill_a_q) >= 32'(WAYS)) begin
					res_status = kpht_pkg::ST_FULL;
				end else begin
					d_we       = 1'b1;
					d_wdata    = new_row;
					f_we       = 1'b1;
					f_wdata    = fill_a_q + FW'(1);
					res_status = kpht_pkg::ST_NEW;
					res_ev     = 1'b1;
					res_key    = job_q.key;
					res_mask   = job_q.bit_mask;
				end
			end
			kpht_pkg::BK_CLR: begin
				f_we    = 1'b1;
				f_waddr = clr_cnt_q;
				if (clr_last) begin
					res_load = 1'b1;
					state_d  = kpht_pkg::BK_IDLE;
				end
			end
			default: state_d = kpht_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kpht_pkg::BK_INIT;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kpht_pkg::BK_INIT || state_q == kpht_pkg::BK_CLR) begin
				clr_cnt_q <= clr_last ? '0 : clr_cnt_q + BW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			job_q <= pop_job;
			bk_q  <= pop_bk;
			br_q  <= pop_br;
		end
		if (state_q == kpht_pkg::BK_CA) begin
			// hold the home row in case the insert ends in a new entry
			row_a_q  <= d_rdata;
			fill_a_q <= f_rdata;
		end
		if (res_load) begin
			out_status_q <= res_status;
			out_ev_q     <= res_ev;
			out_key_q    <= res_key;
			out_mask_q   <= res_mask;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.entry_valid  = out_ev_q;
	assign rsp.entry_key    = out_key_q;
	assign rsp.species_mask = out_mask_q;

	`KPHT_ASSERT_IMP(a_no_overwrite, clk, arst_n, res_load, !out_valid_q, "result overwritten")
	`KPHT_ASSERT_IMP(a_cb_after_rb, clk, arst_n, state_q == kpht_pkg::BK_CB, $past(state_q) == kpht_pkg::BK_RB, "second search out of order")
	`KPHT_ASSERT_IMP(a_fill_with_row, clk, arst_n, f_we && state_q == kpht_pkg::BK_CB, d_we && d_waddr == f_waddr, "fill bump without row write")
endmodule
